[hw/rtl/bbw_pkg.sv]
// ----------------------------------------------------------------------------
// bbw_pkg
// Shared types, codes and the raster op function of the blitter word datapath.
// ----------------------------------------------------------------------------
package bbw_pkg;

   localparam int MAX_PLANES = 16;
   localparam int WORD_W     = 16;
   localparam int BUF_W      = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REQ_PREFETCH = 3'd0,
      REQ_FIRST    = 3'd1,
      REQ_MIDDLE   = 3'd2,
      REQ_LAST     = 3'd3,
      REQ_ONLY     = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      REG_SKEW      = 3'd0,
      REG_DST_START = 3'd1,
      REG_DST_END   = 3'd2,
      REG_DIRECTION = 3'd3,
      REG_OP_TABLE  = 3'd4,
      REG_FG_COLOUR = 3'd5,
      REG_BG_COLOUR = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      ROP_CLEAR    = 4'd0,
      ROP_AND      = 4'd1,
      ROP_AND_REV  = 4'd2,
      ROP_COPY     = 4'd3,
      ROP_AND_INV  = 4'd4,
      ROP_NOOP     = 4'd5,
      ROP_XOR      = 4'd6,
      ROP_OR       = 4'd7,
      ROP_NOR      = 4'd8,
      ROP_EQUIV    = 4'd9,
      ROP_INVERT   = 4'd10,
      ROP_OR_REV   = 4'd11,
      ROP_COPY_INV = 4'd12,
      ROP_OR_INV   = 4'd13,
      ROP_NAND     = 4'd14,
      ROP_SET      = 4'd15
   } rop_code_type;

   typedef struct packed {
      logic [3:0]        skew;
      logic [3:0]        dst_start_bit;
      logic [3:0]        dst_end_bit;
      logic              direction;
      logic [WORD_W-1:0] op_table;
      logic [WORD_W-1:0] fg_colour;
      logic [WORD_W-1:0] bg_colour;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [WORD_W-1:0] src_word;
      logic [WORD_W-1:0] dst_word;
      logic [3:0]        plane;
   } word_item_type;

   typedef struct packed {
      logic              has_result;
      logic [WORD_W-1:0] result_word;
      logic              end_of_line;
   } path_out_type;

   localparam logic [3:0]        SKEW_RST      = 4'd0;
   localparam logic [3:0]        DST_START_RST = 4'd0;
   localparam logic [3:0]        DST_END_RST   = 4'd15;
   localparam logic              DIRECTION_RST = 1'b0;
   localparam logic [WORD_W-1:0] OP_TABLE_RST  = 16'h3333;
   localparam logic [WORD_W-1:0] COLOUR_RST    = 16'h0000;

   function automatic logic [WORD_W-1:0] raster_op(input logic [3:0] code,
                                                   input logic [WORD_W-1:0] s,
                                                   input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] r;
      case (rop_code_type'(code))
         ROP_CLEAR:    r = '0;
         ROP_AND:      r = s & d;
         ROP_AND_REV:  r = s & ~d;
         ROP_COPY:     r = s;
         ROP_AND_INV:  r = ~s & d;
         ROP_NOOP:     r = d;
         ROP_XOR:      r = s ^ d;
         ROP_OR:       r = s | d;
         ROP_NOR:      r = ~(s | d);
         ROP_EQUIV:    r = ~(s ^ d);
         ROP_INVERT:   r = ~d;
         ROP_OR_REV:   r = s | ~d;
         ROP_COPY_INV: r = ~s;
         ROP_OR_INV:   r = ~s | d;
         ROP_NAND:     r = ~(s & d);
         default:      r = '1;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/bbw_if.sv]
// ----------------------------------------------------------------------------
// bbw_req_if / bbw_rsp_if
// Valid/ready word channels into and out of the blitter word datapath.
// ----------------------------------------------------------------------------
interface bbw_req_if;
   import bbw_pkg::*;
   logic              valid;
   logic              ready;
   logic [2:0]        req_type;
   logic [WORD_W-1:0] src_word;
   logic [WORD_W-1:0] dst_word;
   logic [3:0]        plane;

   modport source (output valid, output req_type, output src_word, output dst_word,
                   output plane, input ready);
   modport sink   (input valid, input req_type, input src_word, input dst_word,
                   input plane, output ready);
endinterface

interface bbw_rsp_if;
   import bbw_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] result_word;
   logic              end_of_line;

   modport source (output valid, output result_word, output end_of_line, input ready);
   modport sink   (input valid, input result_word, input end_of_line, output ready);
endinterface

[hw/rtl/bbw_csr.sv]
// ----------------------------------------------------------------------------
// bbw_csr
// APB-style configuration registers: skew, end mask bits, direction, op table
// and colours.
// ----------------------------------------------------------------------------
module bbw_csr import bbw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SKEW:      cfg_in.skew          = csr_pwdata[3:0];
            REG_DST_START: cfg_in.dst_start_bit = csr_pwdata[3:0];
            REG_DST_END:   cfg_in.dst_end_bit   = csr_pwdata[3:0];
            REG_DIRECTION: cfg_in.direction     = csr_pwdata[0];
            REG_OP_TABLE:  cfg_in.op_table      = csr_pwdata[WORD_W-1:0];
            REG_FG_COLOUR: cfg_in.fg_colour     = csr_pwdata[WORD_W-1:0];
            REG_BG_COLOUR: cfg_in.bg_colour     = csr_pwdata[WORD_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         REG_SKEW:      csr_prdata[3:0]        = cfg_ff.skew;
         REG_DST_START: csr_prdata[3:0]        = cfg_ff.dst_start_bit;
         REG_DST_END:   csr_prdata[3:0]        = cfg_ff.dst_end_bit;
         REG_DIRECTION: csr_prdata[0]          = cfg_ff.direction;
         REG_OP_TABLE:  csr_prdata[WORD_W-1:0] = cfg_ff.op_table;
         REG_FG_COLOUR: csr_prdata[WORD_W-1:0] = cfg_ff.fg_colour;
         REG_BG_COLOUR: csr_prdata[WORD_W-1:0] = cfg_ff.bg_colour;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.skew          <= SKEW_RST;
         cfg_ff.dst_start_bit <= DST_START_RST;
         cfg_ff.dst_end_bit   <= DST_END_RST;
         cfg_ff.direction     <= DIRECTION_RST;
         cfg_ff.op_table      <= OP_TABLE_RST;
         cfg_ff.fg_colour     <= COLOUR_RST;
         cfg_ff.bg_colour     <= COLOUR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/bbw_word_path.sv]
// ----------------------------------------------------------------------------
// bbw_word_path
// Shift buffer, skew shift, op selection, raster op and end masking for one
// staged word.
// ----------------------------------------------------------------------------
module bbw_word_path import bbw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  word_item_type item,
   input  logic          commit,
   output path_out_type  path_out
);

   logic [BUF_W-1:0]  buf_ff;
   logic [BUF_W-1:0]  buf_in;
   logic              prefetched_ff;
   logic              prefetched_in;
   logic [WORD_W-1:0] lmask;
   logic [WORD_W-1:0] rmask;
   logic [WORD_W-1:0] mask;
   logic [1:0]        op_idx;
   logic [3:0]        op_code;
   logic [BUF_W-1:0]  shifted;
   logic [WORD_W-1:0] src_op;
   logic [WORD_W-1:0] op_res;
   logic [BUF_W-1:0]  src_lo;
   logic [BUF_W-1:0]  src_hi;
   logic              rtl;
   logic              has_res;
   logic              eol;

   assign rtl    = cfg.direction;
   assign src_lo = {{(BUF_W-WORD_W){1'b0}}, item.src_word};
   assign src_hi = {item.src_word, {(BUF_W-WORD_W){1'b0}}};
   assign lmask  = 16'hffff >> cfg.dst_start_bit;
   assign rmask  = ~(16'h7fff >> cfg.dst_end_bit);

   always_comb begin
      buf_in        = buf_ff;
      prefetched_in = prefetched_ff;
      mask          = '1;
      has_res       = 1'b0;
      eol           = 1'b0;
      case (req_code_type'(item.req_type))
         REQ_PREFETCH: begin
            buf_in        = rtl ? src_lo : src_hi;
            prefetched_in = 1'b1;
         end
         REQ_FIRST: begin
            buf_in        = (prefetched_ff ? buf_ff : '0) | (rtl ? src_hi : src_lo);
            prefetched_in = 1'b0;
            mask          = rtl ? rmask : lmask;
            has_res       = 1'b1;
         end
         REQ_ONLY: begin
            buf_in        = (prefetched_ff ? buf_ff : '0) | (rtl ? src_hi : src_lo);
            prefetched_in = 1'b0;
            mask          = lmask & rmask;
            has_res       = 1'b1;
            eol           = 1'b1;
         end
         REQ_MIDDLE: begin
            buf_in = rtl ? ((buf_ff >> WORD_W) | src_hi) : ((buf_ff << WORD_W) | src_lo);
            has_res = 1'b1;
         end
         REQ_LAST: begin
            buf_in = rtl ? ((buf_ff >> WORD_W) | src_hi) : ((buf_ff << WORD_W) | src_lo);
            mask   = rtl ? lmask : rmask;
            has_res = 1'b1;
            eol     = 1'b1;
         end
         default: begin
            buf_in        = buf_ff;
            prefetched_in = prefetched_ff;
         end
      endcase
   end

   always_comb begin
      op_idx = 2'b00;
      if (int'(item.plane) < MAX_PLANES) begin
         op_idx = {cfg.fg_colour[item.plane], cfg.bg_colour[item.plane]};
      end
   end

   assign op_code = cfg.op_table[{op_idx, 2'b00} +: 4];
   assign shifted = buf_in >> cfg.skew;
   assign src_op  = shifted[WORD_W-1:0];
   assign op_res  = raster_op(op_code, src_op, item.dst_word);
   assign path_out.has_result  = has_res;
   assign path_out.end_of_line = eol;
   assign path_out.result_word = (item.dst_word & ~mask) | (op_res & mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff        <= '0;
         prefetched_ff <= 1'b0;
      end else if (commit) begin
         buf_ff        <= buf_in;
         prefetched_ff <= prefetched_in;
      end
   end

endmodule

[hw/rtl/bitblt_word_datapath.sv]
// ----------------------------------------------------------------------------
// bitblt_word_datapath
// Word datapath of a bitplane blitter: input register, shift and raster op,
// result register, APB configuration registers.
// ----------------------------------------------------------------------------
// An accepted word is held in the input register, its result in the result
// register. Throughput: one word per cycle while the receiver does not stall,
// set by the single pass from the input register through shift, op and mask
// into the result register.
// Reset clears the shift buffer, the prefetch flag and both valid flags, and
// returns the configuration registers to their reset values.
module bitblt_word_datapath import bbw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bbw_req_if.sink               req_if,
   bbw_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg;
   word_item_type     s1_item_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   path_out_type      path_out;
   logic              s1_fire;
   logic              advance;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_eol_ff;
   logic              req_fire;

   bbw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbw_word_path u_path (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .item     (s1_item_ff),
      .commit   (s1_fire),
      .path_out (path_out)
   );

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire      = s1_valid_ff && (advance || !path_out.has_result);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_fire     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && path_out.has_result) ? 1'b1 :
                         (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_word = rsp_word_ff;
   assign rsp_if.end_of_line = rsp_eol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.req_type <= req_if.req_type;
         s1_item_ff.src_word <= req_if.src_word;
         s1_item_ff.dst_word <= req_if.dst_word;
         s1_item_ff.plane    <= req_if.plane;
      end
      if (s1_fire && path_out.has_result) begin
         rsp_word_ff <= path_out.result_word;
         rsp_eol_ff  <= path_out.end_of_line;
      end
   end

endmodule

[hw/rtl/bbw_checker.sv]
// ----------------------------------------------------------------------------
// bbw_checker
// Port-level checks of the blitter word datapath, bound to the top level.
// ----------------------------------------------------------------------------
module bbw_checker import bbw_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   bbw_req_if.sink              req_if,
   bbw_rsp_if.source            rsp_if,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata
);

   logic req_fire;
   logic csr_wr;

   assign req_fire = req_if.valid && req_if.ready;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=>
         $stable(rsp_if.result_word) && $stable(rsp_if.end_of_line))
      else $error("stalled result word changed");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(req_fire, 2))
      else $error("result word without an accepted input word");

   a_op_table_rb: assert property (@(posedge clock) disable iff (reset)
      csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == REG_OP_TABLE)
         ##1 (csr_paddr[CSR_ADDR_W-1:2] == REG_OP_TABLE) && !csr_wr
      |-> csr_prdata[WORD_W-1:0] == $past(csr_pwdata[WORD_W-1:0]))
      else $error("op table readback mismatch");

endmodule

bind bitblt_word_datapath bbw_checker u_bbw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_if      (req_if),
   .rsp_if      (rsp_if),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

[sim/bitblt_word_datapath_tb.sv]
// ----------------------------------------------------------------------------
// bitblt_word_datapath_tb
// Drives blitter lines (prefetch, first, middle, last and only words) through
// the word datapath under several register settings and idle patterns. Each
// accepted word goes through a shadow copy of the shift buffer, raster op and
// end masks; every result word is checked in order against it.
// ----------------------------------------------------------------------------
module bitblt_word_datapath_tb;
   import bbw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_WORDS  = 104;
   localparam int RANDOM_PHASES = 12;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic              eol;
   } line_word_type;

   logic clock = 1'b0;
   logic reset;

   bbw_req_if req_ch ();
   bbw_rsp_if rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type           shadow_cfg;
   logic [BUF_W-1:0]  shadow_buf;
   logic              shadow_prefetched;
   line_word_type     pending_words[$];
   int                words_counted;
   int                fail_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                hold_len;
   int                hold_requests;

   bitblt_word_datapath dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // shadow datapath: buffer update, op select, shift, op and end mask
   function automatic void predict_word(input word_item_type w);
      logic [WORD_W-1:0] lmask, rmask, mask, s, opres, d;
      logic [BUF_W-1:0]  shifted;
      logic [1:0]        sel;
      logic [3:0]        code;
      logic              rtl;
      line_word_type     e;
      rtl = shadow_cfg.direction;
      d = w.dst_word;
      if (w.req_type > REQ_ONLY) return;
      lmask = 16'hffff >> shadow_cfg.dst_start_bit;
      rmask = ~(16'h7fff >> shadow_cfg.dst_end_bit);
      case (w.req_type)
         REQ_PREFETCH: begin
            shadow_buf = rtl ? {16'h0000, w.src_word} : {w.src_word, 16'h0000};
            shadow_prefetched = 1'b1;
            return;
         end
         REQ_FIRST, REQ_ONLY: begin
            if (!shadow_prefetched) shadow_buf = '0;
            shadow_prefetched = 1'b0;
            shadow_buf |= rtl ? {w.src_word, 16'h0000} : {16'h0000, w.src_word};
         end
         default: begin
            if (rtl) shadow_buf = {w.src_word, shadow_buf[31:16]};
            else shadow_buf = {shadow_buf[15:0], w.src_word};
         end
      endcase
      case (w.req_type)
         REQ_ONLY:  mask = lmask & rmask;
         REQ_FIRST: mask = rtl ? rmask : lmask;
         REQ_LAST:  mask = rtl ? lmask : rmask;
         default:   mask = 16'hffff;
      endcase
      sel = 2'b00;
      if (int'(w.plane) < MAX_PLANES)
         sel = {shadow_cfg.fg_colour[w.plane], shadow_cfg.bg_colour[w.plane]};
      code = shadow_cfg.op_table[sel*4 +: 4];
      shifted = shadow_buf >> shadow_cfg.skew;
      s = shifted[WORD_W-1:0];
      // op code read as a truth table over inverted source and destination bits
      for (int i = 0; i < WORD_W; i++) opres[i] = code[{~s[i], ~d[i]}];
      e.word = (d & ~mask) | (opres & mask);
      e.eol = (w.req_type == REQ_LAST) || (w.req_type == REQ_ONLY);
      pending_words.push_back(e);
      words_counted++;
   endfunction

   task automatic send_word(input logic [2:0] kind, input logic [WORD_W-1:0] src,
                            input logic [WORD_W-1:0] dst, input logic [3:0] plane);
      word_item_type w;
      w.req_type = kind;
      w.src_word = src;
      w.dst_word = dst;
      w.plane = plane;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= w.req_type;
      req_ch.src_word <= w.src_word;
      req_ch.dst_word <= w.dst_word;
      req_ch.plane <= w.plane;
      do @(posedge clock); while (!req_ch.ready);
      predict_word(w);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_SKEW:      shadow_cfg.skew = value[3:0];
         REG_DST_START: shadow_cfg.dst_start_bit = value[3:0];
         REG_DST_END:   shadow_cfg.dst_end_bit = value[3:0];
         REG_DIRECTION: shadow_cfg.direction = value[0];
         REG_OP_TABLE:  shadow_cfg.op_table = value[15:0];
         REG_FG_COLOUR: shadow_cfg.fg_colour = value[15:0];
         REG_BG_COLOUR: shadow_cfg.bg_colour = value[15:0];
         default: ;
      endcase
   endtask

   task automatic program_config(input logic [3:0] skew, input logic [3:0] start_bit,
                                 input logic [3:0] end_bit, input logic dir,
                                 input logic [15:0] ops, input logic [15:0] fg,
                                 input logic [15:0] bg);
      csr_write(REG_SKEW, 32'(skew));
      csr_write(REG_DST_START, 32'(start_bit));
      csr_write(REG_DST_END, 32'(end_bit));
      csr_write(REG_DIRECTION, 32'(dir));
      csr_write(REG_OP_TABLE, 32'(ops));
      csr_write(REG_FG_COLOUR, 32'(fg));
      csr_write(REG_BG_COLOUR, 32'(bg));
   endtask

   // mostly well-formed lines, some stray codes and broken sequences
   task automatic send_line();
      logic [3:0] pl;
      int         n_mid;
      pl = 4'($urandom_range(15));
      if ($urandom_range(99) < 8) begin
         send_word(3'($urandom_range(7)), 16'($urandom), 16'($urandom), pl);
         return;
      end
      if ($urandom_range(1) == 1) send_word(REQ_PREFETCH, 16'($urandom), 16'($urandom), pl);
      if ($urandom_range(3) == 0) begin
         send_word(REQ_ONLY, 16'($urandom), 16'($urandom), pl);
      end else begin
         send_word(REQ_FIRST, 16'($urandom), 16'($urandom), pl);
         n_mid = $urandom_range(5);
         repeat (n_mid) send_word(REQ_MIDDLE, 16'($urandom), 16'($urandom), pl);
         send_word(REQ_LAST, 16'($urandom), 16'($urandom), pl);
      end
   endtask

   task automatic test_raster_ops();
      logic [3:0] c;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // plane p picks entry p[1:0]; planes 0..15 walk all sixteen codes
      for (int g = 0; g < 4; g++) begin
         c = 4'(g * 4);
         program_config(4'd0, 4'd0, 4'd15, 1'b0, {c + 4'd3, c + 4'd2, c + 4'd1, c},
                        16'hcccc, 16'haaaa);
         for (int k = 0; k < 4; k++) send_word(REQ_ONLY, 16'h00ff, 16'h0f0f, c + 4'(k));
         wait_drained();
      end
   endtask

   task automatic test_special_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // start bit after end bit: empty mask keeps the destination
      program_config(4'd0, 4'd8, 4'd3, 1'b0, 16'h6f30, 16'h00ff, 16'h0f0f);
      send_word(REQ_ONLY, 16'hffff, 16'h1234, 4'd5);
      for (int c = int'(REQ_ONLY) + 1; c < 8; c++)
         send_word(3'(c), 16'($urandom), 16'($urandom), 4'($urandom_range(15)));
      // middle and last with no first word
      send_word(REQ_MIDDLE, 16'hffff, 16'h0000, 4'd0);
      send_word(REQ_LAST, 16'h0000, 16'hffff, 4'd15);
      wait_drained();
      program_config(4'd15, 4'd15, 4'd0, 1'b1, 16'h3c69, 16'hf0f0, 16'hff00);
      send_word(REQ_PREFETCH, 16'ha5a5, 16'h0000, 4'd4);
      send_word(REQ_FIRST, 16'h5a5a, 16'hffff, 4'd12);
      send_word(REQ_LAST, 16'h0000, 16'h0000, 4'd15);
      wait_drained();
   endtask

   task automatic test_random_lines();
      int target;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 64; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         if (ph == 0)
            program_config(4'd0, 4'd0, 4'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
         else if (ph == 1)
            program_config(4'd15, 4'd15, 4'd15, 1'b1, 16'hffff, 16'hffff, 16'hffff);
         else
            program_config(4'($urandom_range(15)), 4'($urandom_range(15)),
                           4'($urandom_range(15)), 1'($urandom_range(1)),
                           16'($urandom), 16'($urandom), 16'($urandom));
         target = words_counted + PHASE_WORDS;
         while (words_counted < target) send_line();
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      int target;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      program_config(4'd7, 4'd3, 4'd12, 1'b0, 16'h9631, 16'h5a5a, 16'h3c3c);
      hold_len = 300;
      hold_requests++;
      target = words_counted + 40;
      while (words_counted < target) send_line();
      wait_drained();
   endtask

   task automatic test_sender_pause();
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      program_config(4'd9, 4'd1, 4'd14, 1'b1, 16'he7b4, 16'h1234, 16'h8765);
      repeat (4) begin
         send_line();
         req_ch.valid <= 1'b0;
         while (pending_words.size() != 0) @(posedge clock);
         @(negedge clock);
      end
      wait_drained();
   endtask

   // receiver: random stalls plus a counted long hold-off on request
   initial begin
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      line_word_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word exp none got %h/%b", $time,
                     rsp_ch.result_word, rsp_ch.end_of_line);
            fail_count++;
         end else begin
            e = pending_words.pop_front();
            if (rsp_ch.result_word !== e.word) begin
               $display("%0t: result_word exp %h got %h", $time, e.word, rsp_ch.result_word);
               fail_count++;
            end
            if (rsp_ch.end_of_line !== e.eol) begin
               $display("%0t: end_of_line exp %b got %b", $time, e.eol, rsp_ch.end_of_line);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_PREFETCH;
      req_ch.src_word = '0;
      req_ch.dst_word = '0;
      req_ch.plane = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      shadow_cfg = '{SKEW_RST, DST_START_RST, DST_END_RST, DIRECTION_RST, OP_TABLE_RST,
                     COLOUR_RST, COLOUR_RST};
      shadow_buf = '0;
      shadow_prefetched = 1'b0;
      words_counted = 0;
      fail_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_len = 0;
      hold_requests = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_raster_ops();
      test_special_cases();
      test_random_lines();
      test_backpressure();
      test_sender_pause();

      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
